// ===== rtl/ssc_pkg.sv =====
// Shared types, constants and coefficient tables of the fourth-order state-space controller.
// Used by every module of the controller; depends on nothing else.
`default_nettype none

package ssc_pkg;

    localparam int STATE_ORDER = 4;
    localparam int ROW_W       = $clog2(STATE_ORDER);
    localparam int COL_W       = ROW_W + 1;
    localparam int MEM_DEPTH   = 2 * STATE_ORDER;
    localparam int MEM_AW      = ROW_W + 1;

    localparam int X_W      = 48;
    localparam int COEF_W   = 40;
    localparam int ERR_W    = 17;
    localparam int DUTY_W   = 10;
    localparam int RAW_W    = 32;
    localparam int FRAC_X   = 16;
    localparam int HALF_W   = 24;
    localparam int PROD_W   = COEF_W + HALF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CFG_W    = 10;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam logic [CFG_W-1:0] OFFSET_RESET = 10'd660;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 10'd1023;

    localparam logic REG_OUTPUT_OFFSET = 1'b0;
    localparam logic REG_DRIVE_LIMIT   = 1'b1;

    localparam logic [COL_W-1:0] COL_B      = 3'd4;
    localparam logic [COL_W-1:0] DRAIN_LAST = 3'd3;
    localparam logic [ROW_W-1:0] LAST_ROW   = 2'd3;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATE,
        ST_DRAIN,
        ST_OUTPUT,
        ST_WAIT,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        TERM_A,
        TERM_B,
        TERM_C,
        TERM_OFS
    } term_kind_t;

    typedef struct packed {
        logic             valid;
        term_kind_t       kind;
        logic [ROW_W-1:0] row;
        logic             wr_bank;
        logic             first;
        logic             write;
        logic             last_term;
    } term_ctl_t;

    typedef struct packed {
        seq_state_t state;
        logic       bank;
    } seq_status_t;

    localparam coef_t COEF_A [STATE_ORDER][STATE_ORDER] = '{
        '{ 40'sd16762117, 40'sd0, 40'sd0, 40'sd0 },
        '{ 40'sd4513071, -40'sd5924, 40'sd407, -40'sd72 },
        '{ 40'sd4672454656, -40'sd5947523, 40'sd409029, -40'sd72780 },
        '{ 40'sd23370661888, 40'sd687698084, -40'sd47278195, 40'sd8417129 }
    };

    localparam coef_t COEF_B [STATE_ORDER] = '{
        40'sd670753, -40'sd526133, -40'sd540394127, 40'sd14430083482
    };

    localparam coef_t COEF_C [STATE_ORDER] = '{
        40'sd2533359616, 40'sd717897073, -40'sd8792939, -40'sd207870
    };

    function automatic coef_t coef_lookup(term_kind_t kind, logic [ROW_W-1:0] row,
                                          logic [ROW_W-1:0] col);
        coef_t c;
        case (kind)
            TERM_A: c = COEF_A[row][col];
            TERM_B: c = COEF_B[row];
            TERM_C: c = COEF_C[col];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssc_state_mem.sv =====
// Ping-pong state memory: two banks of controller state, one write and one read port.
// Reads are registered; entries never written since reset read as zero. Uses ssc_pkg.
`default_nettype none

module ssc_state_mem (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [ssc_pkg::MEM_AW-1:0]     rd_addr,
    output logic signed [ssc_pkg::X_W-1:0]      rd_data,
    input  wire logic                           wr_en,
    input  wire logic [ssc_pkg::MEM_AW-1:0]     wr_addr,
    input  wire logic signed [ssc_pkg::X_W-1:0] wr_data
);

    logic signed [ssc_pkg::X_W-1:0] mem_reg [ssc_pkg::MEM_DEPTH];
    logic [ssc_pkg::MEM_DEPTH-1:0]  valid_reg;
    logic signed [ssc_pkg::X_W-1:0] q_reg;
    logic                           qv_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        q_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end else begin
            qv_reg <= valid_reg[rd_addr];
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = qv_reg ? q_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/ssc_sequencer.sv =====
// Term sequencer: walks the state update, drain, output and finish phases and issues one
// multiply-accumulate term per cycle with its memory read address and coefficient. Uses ssc_pkg.
`default_nettype none

module ssc_sequencer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       acc_done,
    input  wire logic                       out_free,
    output ssc_pkg::term_ctl_t              issue,
    output ssc_pkg::coef_t                  coef,
    output logic [ssc_pkg::MEM_AW-1:0]      rd_addr,
    output logic                            load_result,
    output ssc_pkg::seq_status_t            status
);

    ssc_pkg::seq_state_t          state_reg, state_next;
    logic [ssc_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [ssc_pkg::COL_W-1:0]    col_reg, col_next;
    logic                         bank_reg, bank_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssc_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            bank_reg  <= bank_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ssc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = ssc_pkg::ST_STATE;
                end
            end
            ssc_pkg::ST_STATE: begin
                if (row_reg == ssc_pkg::LAST_ROW && col_reg == ssc_pkg::COL_B) begin
                    state_next = ssc_pkg::ST_DRAIN;
                end
            end
            ssc_pkg::ST_DRAIN: begin
                if (col_reg == ssc_pkg::DRAIN_LAST) begin
                    state_next = ssc_pkg::ST_OUTPUT;
                end
            end
            ssc_pkg::ST_OUTPUT: begin
                if (col_reg == ssc_pkg::COL_B) begin
                    state_next = ssc_pkg::ST_WAIT;
                end
            end
            ssc_pkg::ST_WAIT: begin
                if (acc_done) begin
                    state_next = ssc_pkg::ST_FINISH;
                end
            end
            ssc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default: state_next = ssc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        case (state_reg)
            ssc_pkg::ST_IDLE: begin
                row_next = '0;
                col_next = '0;
            end
            ssc_pkg::ST_STATE: begin
                if (col_reg == ssc_pkg::COL_B) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ssc_pkg::ST_DRAIN: begin
                if (col_reg == ssc_pkg::DRAIN_LAST) begin
                    col_next = '0;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ssc_pkg::ST_OUTPUT: begin
                if (col_reg == ssc_pkg::COL_B) begin
                    col_next = '0;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ssc_pkg::ST_FINISH: begin
                if (out_free) begin
                    bank_next = ~bank_reg;
                end
            end
            default: begin
                row_next = row_reg;
            end
        endcase
    end

    always_comb begin
        in_ready          = 1'b0;
        load_result       = 1'b0;
        issue             = '0;
        issue.kind        = ssc_pkg::TERM_A;
        issue.row         = row_reg;
        issue.wr_bank     = ~bank_reg;
        rd_addr           = {bank_reg, col_reg[ssc_pkg::ROW_W-1:0]};
        case (state_reg)
            ssc_pkg::ST_IDLE: begin
                in_ready = aresetn;
            end
            ssc_pkg::ST_STATE: begin
                issue.valid = 1'b1;
                issue.kind  = (col_reg == ssc_pkg::COL_B) ? ssc_pkg::TERM_B : ssc_pkg::TERM_A;
                issue.first = (col_reg == '0);
                issue.write = (col_reg == ssc_pkg::COL_B);
            end
            ssc_pkg::ST_OUTPUT: begin
                issue.valid     = 1'b1;
                issue.kind      = (col_reg == ssc_pkg::COL_B) ? ssc_pkg::TERM_OFS
                                                              : ssc_pkg::TERM_C;
                issue.row       = '0;
                issue.first     = (col_reg == '0);
                issue.last_term = (col_reg == ssc_pkg::COL_B);
                rd_addr         = {~bank_reg, col_reg[ssc_pkg::ROW_W-1:0]};
            end
            ssc_pkg::ST_FINISH: begin
                load_result = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        coef = ssc_pkg::coef_lookup(issue.kind, issue.row, col_reg[ssc_pkg::ROW_W-1:0]);
    end

    assign status = {state_reg, bank_reg};

endmodule

`default_nettype wire

// ===== rtl/ssc_mac.sv =====
// Four-stage multiply-accumulate datapath: operand select, split multiply, rounding and
// magnitude clamp, then saturating accumulate with state write-back. Uses ssc_pkg.
`default_nettype none

module ssc_mac (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ssc_pkg::term_ctl_t               issue,
    input  wire ssc_pkg::coef_t                   coef,
    input  wire logic signed [ssc_pkg::X_W-1:0]   mem_q,
    input  wire logic signed [ssc_pkg::ERR_W-1:0] error,
    input  wire logic [ssc_pkg::CFG_W-1:0]        offset,
    output logic                                  wr_en,
    output logic [ssc_pkg::MEM_AW-1:0]            wr_addr,
    output logic signed [ssc_pkg::X_W-1:0]        wr_data,
    output logic signed [ssc_pkg::X_W-1:0]        acc,
    output logic                                  acc_done
);

    localparam int X_W    = ssc_pkg::X_W;
    localparam int COEF_W = ssc_pkg::COEF_W;
    localparam int HALF_W = ssc_pkg::HALF_W;
    localparam int PROD_W = ssc_pkg::PROD_W;
    localparam int SUM_W  = ssc_pkg::SUM_W;

    localparam logic [SUM_W-1:0] RND_Q24  = SUM_W'(1) << 23;
    localparam logic [SUM_W-1:0] RND_ERR  = SUM_W'(1) << 14;
    localparam logic [SUM_W-1:0] LIM_POS  = (SUM_W'(1) << (X_W - 1)) - 1'b1;
    localparam logic [SUM_W-1:0] LIM_NEG  = SUM_W'(1) << (X_W - 1);
    localparam logic [X_W-1:0]   ACC_MAX  = {1'b0, {(X_W-1){1'b1}}};
    localparam logic [X_W-1:0]   ACC_MIN  = {1'b1, {(X_W-1){1'b0}}};

    ssc_pkg::term_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic [COEF_W-1:0] cmag1_reg, cmag2_reg;
    logic              cneg1_reg;
    logic [X_W-1:0]    xmag2_reg;
    logic              neg2_reg, neg3_reg, neg4_reg;
    logic [PROD_W-1:0] phi3_reg, plo3_reg;
    logic [X_W-1:0]    mag4_reg;
    logic signed [X_W-1:0] acc_reg;

    logic [COEF_W-1:0]     cmag1_next;
    logic signed [X_W-1:0] x1;
    logic [X_W-1:0]        xmag2_next;
    logic [PROD_W-1:0]     phi3_next, plo3_next;
    logic [SUM_W-1:0]      plo_rnd_q24, plo_rnd_err, mag3, lim3, mag3_sat;
    logic                  neg3_eff;
    logic signed [X_W-1:0] base4;
    logic [X_W:0]          sum4;
    logic signed [X_W-1:0] acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    // Stage 0 to 1: coefficient magnitude and sign.
    assign cmag1_next = coef[COEF_W-1] ? (~coef + 1'b1) : coef;

    // Stage 1 to 2: operand magnitude and product sign.
    assign x1 = (ctl1_reg.kind == ssc_pkg::TERM_B)
              ? {{(X_W-ssc_pkg::ERR_W){error[ssc_pkg::ERR_W-1]}}, error}
              : mem_q;
    assign xmag2_next = x1[X_W-1] ? (~x1 + 1'b1) : x1;

    // Stage 2 to 3: the operand is split in two halves, each a 40 by 24 product.
    assign phi3_next = {{HALF_W{1'b0}}, cmag2_reg} * {{COEF_W{1'b0}}, xmag2_reg[X_W-1:HALF_W]};
    assign plo3_next = {{HALF_W{1'b0}}, cmag2_reg} * {{COEF_W{1'b0}}, xmag2_reg[HALF_W-1:0]};

    // Stage 3: round to Q16 and clamp the magnitude to the 48-bit range of its sign.
    assign plo_rnd_q24 = {1'b0, plo3_reg} + RND_Q24;
    assign plo_rnd_err = {1'b0, plo3_reg} + RND_ERR;

    always_comb begin
        neg3_eff = neg3_reg;
        case (ctl3_reg.kind)
            ssc_pkg::TERM_B: begin
                mag3 = {15'b0, plo_rnd_err[SUM_W-1:15]};
            end
            ssc_pkg::TERM_OFS: begin
                mag3     = {{(SUM_W-ssc_pkg::CFG_W-ssc_pkg::FRAC_X){1'b0}}, offset,
                            {ssc_pkg::FRAC_X{1'b0}}};
                neg3_eff = 1'b0;
            end
            default: begin
                mag3 = {1'b0, phi3_reg} + {24'b0, plo_rnd_q24[SUM_W-1:24]};
            end
        endcase
        lim3     = neg3_eff ? LIM_NEG : LIM_POS;
        mag3_sat = (mag3 > lim3) ? lim3 : mag3;
    end

    // Stage 4: saturating accumulate.
    assign base4 = ctl4_reg.first ? '0 : acc_reg;
    assign sum4  = neg4_reg ? ({base4[X_W-1], base4} - {1'b0, mag4_reg})
                            : ({base4[X_W-1], base4} + {1'b0, mag4_reg});

    always_comb begin
        if (sum4[X_W] != sum4[X_W-1]) begin
            acc_next = sum4[X_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = sum4[X_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        cmag1_reg <= cmag1_next;
        cneg1_reg <= coef[COEF_W-1];
        cmag2_reg <= cmag1_reg;
        xmag2_reg <= xmag2_next;
        neg2_reg  <= cneg1_reg ^ x1[X_W-1];
        phi3_reg  <= phi3_next;
        plo3_reg  <= plo3_next;
        neg3_reg  <= neg2_reg;
        mag4_reg  <= mag3_sat[X_W-1:0];
        neg4_reg  <= neg3_eff;
        if (ctl4_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign wr_en    = ctl4_reg.valid & ctl4_reg.write;
    assign wr_addr  = {ctl4_reg.wr_bank, ctl4_reg.row};
    assign wr_data  = acc_next;
    assign acc      = acc_reg;
    assign acc_done = ctl4_reg.valid & ctl4_reg.last_term;

endmodule

`default_nettype wire

// ===== rtl/state_space_controller_4th_order.sv =====
// Top level of the fourth-order state-space controller: stream ports, configuration
// registers and output register. Uses ssc_pkg, ssc_state_mem, ssc_sequencer and ssc_mac.
//
//   Channel   Direction  Beat contents
//   s_*       in         tdata: error_sample[16:0]
//   m_*       out        tdata: pwm_duty[9:0], raw_output[41:10]; tuser: clamped
//   APB       in/out     0x0 output_offset, 0x4 drive_limit (10 bits each)
//
// A beat is accepted only while the sequencer is idle; the next one is taken once the sequencer
// has walked its state update, drain, output, wait and finish phases. One multiply-accumulate term
// issues per cycle, in the state update and output phases, from a single split-multiplier pipeline.
// The result is loaded into the output register in the finish phase, once m_* is free.
// Reset is synchronous; the state memory reads as zero until written, with no clearing pass.
// If the previous result is still waiting, the finish cycle holds until it is taken.
`default_nettype none

module state_space_controller_4th_order (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ssc_pkg::S_TDATA_W-1:0]     s_tdata,   // [16:0] error_sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ssc_pkg::M_TDATA_W-1:0]          m_tdata,   // [9:0] pwm_duty, [41:10] raw_output
    output logic                                   m_tuser,   // [0] clamped
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ssc_pkg::APB_AW-1:0]        paddr,
    input  wire logic [ssc_pkg::APB_DW-1:0]        pwdata,
    output logic [ssc_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);

    localparam int X_W    = ssc_pkg::X_W;
    localparam int RAW_W  = ssc_pkg::RAW_W;
    localparam int CFG_W  = ssc_pkg::CFG_W;
    localparam int DUTY_W = ssc_pkg::DUTY_W;

    logic [CFG_W-1:0]                 offset_reg;
    logic [CFG_W-1:0]                 limit_reg;
    logic signed [ssc_pkg::ERR_W-1:0] error_reg;
    logic                             m_tvalid_reg;
    logic [DUTY_W-1:0]                pwm_reg, pwm_next;
    logic                             clamped_reg, clamped_next;
    logic signed [RAW_W-1:0]          raw_reg, raw_next;

    logic                             cfg_write;
    logic                             s_accept;
    logic                             out_free;
    logic                             load_result;
    logic                             acc_done;
    ssc_pkg::term_ctl_t               issue;
    ssc_pkg::coef_t                   coef;
    ssc_pkg::seq_status_t             status;
    logic [ssc_pkg::MEM_AW-1:0]       rd_addr;
    logic signed [X_W-1:0]            mem_q;
    logic                             wr_en;
    logic [ssc_pkg::MEM_AW-1:0]       wr_addr;
    logic signed [X_W-1:0]            wr_data;
    logic signed [X_W-1:0]            acc;
    logic [X_W-1:0]                   acc_trunc;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign s_accept  = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= ssc_pkg::OFFSET_RESET;
            limit_reg  <= ssc_pkg::LIMIT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                ssc_pkg::REG_OUTPUT_OFFSET: offset_reg <= pwdata[CFG_W-1:0];
                ssc_pkg::REG_DRIVE_LIMIT:   limit_reg  <= pwdata[CFG_W-1:0];
                default:                    offset_reg <= offset_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ssc_pkg::REG_OUTPUT_OFFSET: prdata = {{(ssc_pkg::APB_DW-CFG_W){1'b0}}, offset_reg};
            ssc_pkg::REG_DRIVE_LIMIT:   prdata = {{(ssc_pkg::APB_DW-CFG_W){1'b0}}, limit_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            error_reg <= s_tdata[ssc_pkg::ERR_W-1:0];
        end
    end

    ssc_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .acc_done    (acc_done),
        .out_free    (out_free),
        .issue       (issue),
        .coef        (coef),
        .rd_addr     (rd_addr),
        .load_result (load_result),
        .status      (status)
    );

    ssc_state_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (mem_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ssc_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .coef     (coef),
        .mem_q    (mem_q),
        .error    (error_reg),
        .offset   (offset_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .acc      (acc),
        .acc_done (acc_done)
    );

    // The integer part truncates toward zero, so negative sums are biased before the shift.
    assign acc_trunc = acc + (acc[X_W-1] ? X_W'(16'hFFFF) : X_W'(0));
    assign raw_next  = acc_trunc[X_W-1:ssc_pkg::FRAC_X];

    always_comb begin
        if (raw_next[RAW_W-1]) begin
            pwm_next     = '0;
            clamped_next = 1'b1;
        end else if (raw_next > $signed({{(RAW_W-CFG_W){1'b0}}, limit_reg})) begin
            pwm_next     = limit_reg;
            clamped_next = 1'b1;
        end else begin
            pwm_next     = raw_next[DUTY_W-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            pwm_reg     <= pwm_next;
            clamped_reg <= clamped_next;
            raw_reg     <= raw_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = clamped_reg;
    assign m_tdata  = {{(ssc_pkg::M_TDATA_W-DUTY_W-RAW_W){1'b0}}, raw_reg, pwm_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("Input accepted on two consecutive cycles.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_done |-> (status.state == ssc_pkg::ST_WAIT))
        else $error("Final accumulation out of step with the sequencer.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_addr[ssc_pkg::MEM_AW-1] != status.bank))
        else $error("State write-back hit the bank being read.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[41:10] == {22'b0, m_tdata[9:0]}))
        else $error("Unclamped duty differs from the raw output.");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of state_space_controller_4th_order: error-sample beats in,
// PWM drive beats out, APB register writes and readback. Depends on all of the rtl/ files.

module tb;

    localparam int N_DIRECTED      = 20;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [ssc_pkg::APB_AW-1:0] ADDR_OUTPUT_OFFSET = 3'h0;
    localparam logic [ssc_pkg::APB_AW-1:0] ADDR_DRIVE_LIMIT   = 3'h4;

    localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    localparam longint A_TAB [ssc_pkg::STATE_ORDER][ssc_pkg::STATE_ORDER] = '{
        '{ 64'sd16762117, 64'sd0, 64'sd0, 64'sd0 },
        '{ 64'sd4513071, -64'sd5924, 64'sd407, -64'sd72 },
        '{ 64'sd4672454656, -64'sd5947523, 64'sd409029, -64'sd72780 },
        '{ 64'sd23370661888, 64'sd687698084, -64'sd47278195, 64'sd8417129 }
    };
    localparam longint B_TAB [ssc_pkg::STATE_ORDER] = '{
        64'sd670753, -64'sd526133, -64'sd540394127, 64'sd14430083482
    };
    localparam longint C_TAB [ssc_pkg::STATE_ORDER] = '{
        64'sd2533359616, 64'sd717897073, -64'sd8792939, -64'sd207870
    };

    typedef struct packed {
        logic [ssc_pkg::DUTY_W-1:0] duty;
        logic                       clip;
        logic [ssc_pkg::RAW_W-1:0]  raw;
    } drive_beat_t;

    typedef struct packed {
        logic signed [ssc_pkg::ERR_W-1:0] err;
        logic                             typed;
        logic [ssc_pkg::DUTY_W-1:0]       duty;
        logic                             clip;
        logic [ssc_pkg::RAW_W-1:0]        raw;
    } directed_row_t;

    typedef struct packed {
        logic [ssc_pkg::APB_DW-1:0] offset_word;
        logic [ssc_pkg::APB_DW-1:0] limit_word;
        logic [6:0]                 sender_pct;
        logic [6:0]                 recv_pct;
        logic [9:0]                 hold;
        logic                       pause_mid;
        logic                       rand_cfg;
    } phase_cfg_t;

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ 17'sd0,    1'b1, 10'd660, 1'b0, 32'd660 },
        '{ 17'sd0,    1'b1, 10'd660, 1'b0, 32'd660 },
        '{ 17'sd1,    1'b0, 10'd0, 1'b0, 32'd0 },
        '{ -17'sd1,   1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h0FFFF, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h0FFFF, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h0FFFF, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h10000, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h10000, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h10000, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'sd0,    1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h0AAAA, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h15555, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'sd127,  1'b0, 10'd0, 1'b0, 32'd0 },
        '{ -17'sd128, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'sd300,  1'b0, 10'd0, 1'b0, 32'd0 },
        '{ -17'sd300, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'sd0,    1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h0FFFF, 1'b0, 10'd0, 1'b0, 32'd0 },
        '{ 17'h10000, 1'b0, 10'd0, 1'b0, 32'd0 }
    };

    localparam phase_cfg_t PHASES [N_PHASES] = '{
        '{ 32'd0,          32'd1023,       7'd0,  7'd0,  10'd0,   1'b0, 1'b0 },
        '{ 32'd1023,       32'd1,          7'd59, 7'd0,  10'd0,   1'b1, 1'b0 },
        '{ 32'd512,        32'd0,          7'd0,  7'd59, 10'd0,   1'b0, 1'b0 },
        '{ 32'hFFFF_FE94,  32'h8000_0A0F,  7'd14, 7'd14, 10'd0,   1'b0, 1'b0 },
        '{ 32'd660,        32'd1023,       7'd0,  7'd0,  10'd400, 1'b0, 1'b0 },
        '{ 32'd0,          32'd0,          7'd14, 7'd14, 10'd0,   1'b1, 1'b1 },
        '{ 32'd300,        32'd700,        7'd59, 7'd59, 10'd0,   1'b0, 1'b0 }
    };

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ssc_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ssc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ssc_pkg::APB_AW-1:0]      paddr;
    logic [ssc_pkg::APB_DW-1:0]      pwdata;
    logic [ssc_pkg::APB_DW-1:0]      prdata;
    logic                            pready;

    longint      law_state [ssc_pkg::STATE_ORDER];
    int          cfg_offset;
    int          cfg_limit;
    drive_beat_t expected_beats [$];
    int          error_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_left;

    state_space_controller_4th_order i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint clip48(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint unsigned mag_of(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint signed_mag(longint unsigned m, bit neg);
        longint unsigned lim;
        lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Q24 coefficient times Q16 value, rounded on the magnitude back to Q16.
    function automatic longint coef_mul(longint coef, longint x);
        longint unsigned ua, ux, hi, lo, m;
        ua = mag_of(coef);
        ux = mag_of(x);
        hi = ux >> 24;
        lo = ux & 64'h0000_0000_00FF_FFFF;
        m  = ua * hi + ((ua * lo + (64'd1 << 23)) >> 24);
        return signed_mag(m, (coef < 0) != (x < 0));
    endfunction

    // Q24 coefficient times Q7 error sample, rounded to Q16.
    function automatic longint err_mul(longint coef, longint e);
        longint unsigned m;
        m = (mag_of(coef) * mag_of(e) + (64'd1 << 14)) >> 15;
        return signed_mag(m, (coef < 0) != (e < 0));
    endfunction

    function automatic drive_beat_t step_controller(logic signed [ssc_pkg::ERR_W-1:0] err);
        longint      nxt [ssc_pkg::STATE_ORDER];
        longint      e, acc, rawv;
        drive_beat_t r;
        e = err;
        for (int i = 0; i < ssc_pkg::STATE_ORDER; i++) begin
            acc = 0;
            for (int j = 0; j < ssc_pkg::STATE_ORDER; j++)
                acc = clip48(acc + coef_mul(A_TAB[i][j], law_state[j]));
            nxt[i] = clip48(acc + err_mul(B_TAB[i], e));
        end
        for (int i = 0; i < ssc_pkg::STATE_ORDER; i++)
            law_state[i] = nxt[i];
        acc = 0;
        for (int j = 0; j < ssc_pkg::STATE_ORDER; j++)
            acc = clip48(acc + coef_mul(C_TAB[j], law_state[j]));
        acc = clip48(acc + longint'(cfg_offset) * 65536);
        rawv = (acc < 0) ? -longint'(mag_of(acc) >> 16) : (acc >>> 16);
        if (rawv < 0) begin
            r.duty = '0;
            r.clip = 1'b1;
        end else if (rawv > cfg_limit) begin
            r.duty = cfg_limit[ssc_pkg::DUTY_W-1:0];
            r.clip = 1'b1;
        end else begin
            r.duty = rawv[ssc_pkg::DUTY_W-1:0];
            r.clip = 1'b0;
        end
        r.raw = rawv[ssc_pkg::RAW_W-1:0];
        return r;
    endfunction

    function automatic void flag_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
        error_count++;
        if (error_count <= 10)
            $display("cycle %0d: %s mismatch: expected %0h, got %0h",
                     cycle_count, what, want, got);
    endfunction

    function automatic int draw_gap();
        int g;
        g = 0;
        if (sender_idle_pct == 0) return 0;
        if ($urandom_range(99) < 10) return $urandom_range(45);
        while ($urandom_range(99) < sender_idle_pct) g++;
        return g;
    endfunction

    task automatic offer_sample(input logic signed [ssc_pkg::ERR_W-1:0] err, input bit typed,
                                input drive_beat_t typed_beat);
        int          gap;
        drive_beat_t predicted;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ssc_pkg::S_TDATA_W-ssc_pkg::ERR_W){1'b0}}, err};
        do @(posedge aclk); while (!s_tready);
        predicted = step_controller(err);
        expected_beats.push_back(typed ? typed_beat : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ssc_pkg::APB_AW-1:0] addr,
                             input logic [ssc_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (addr)
            ADDR_OUTPUT_OFFSET: cfg_offset = int'(data[ssc_pkg::CFG_W-1:0]);
            ADDR_DRIVE_LIMIT:   cfg_limit  = int'(data[ssc_pkg::CFG_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic apb_check(input logic [ssc_pkg::APB_AW-1:0] addr, input int want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== ssc_pkg::APB_DW'(want))
            flag_mismatch("register readback", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end else if (hold_left == 0 && recv_stall_pct > 0 && $urandom_range(999) < 8) begin
            hold_left = $urandom_range(60);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        drive_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                flag_mismatch("unexpected result beat", 0, m_tdata);
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata[ssc_pkg::DUTY_W-1:0] !== want.duty)
                    flag_mismatch("pwm_duty", want.duty, m_tdata[ssc_pkg::DUTY_W-1:0]);
                if (m_tuser !== want.clip)
                    flag_mismatch("clamped", want.clip, m_tuser);
                if (m_tdata[ssc_pkg::DUTY_W+ssc_pkg::RAW_W-1:ssc_pkg::DUTY_W] !== want.raw)
                    flag_mismatch("raw_output", want.raw,
                                  m_tdata[ssc_pkg::DUTY_W+ssc_pkg::RAW_W-1:ssc_pkg::DUTY_W]);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        drive_beat_t                      typed_beat;
        phase_cfg_t                       ph;
        logic signed [ssc_pkg::ERR_W-1:0] err;
        int                               run_left;
        int                               run_kind;
        error_count     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        hold_left       = 0;
        run_left        = 0;
        run_kind        = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < ssc_pkg::STATE_ORDER; i++)
            law_state[i] = 0;
        cfg_offset = int'(ssc_pkg::OFFSET_RESET);
        cfg_limit  = int'(ssc_pkg::LIMIT_RESET);
        apb_check(ADDR_OUTPUT_OFFSET, 660);
        apb_check(ADDR_DRIVE_LIMIT, 1023);

        for (int k = 0; k < N_DIRECTED; k++) begin
            typed_beat.duty = DIRECTED_ROWS[k].duty;
            typed_beat.clip = DIRECTED_ROWS[k].clip;
            typed_beat.raw  = DIRECTED_ROWS[k].raw;
            offer_sample(DIRECTED_ROWS[k].err, DIRECTED_ROWS[k].typed, typed_beat);
        end
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            ph = PHASES[p];
            if (ph.rand_cfg) begin
                ph.offset_word = $urandom_range(1023);
                ph.limit_word  = $urandom_range(1023, 1);
            end
            apb_write(ADDR_OUTPUT_OFFSET, ph.offset_word);
            apb_write(ADDR_DRIVE_LIMIT, ph.limit_word);
            apb_check(ADDR_OUTPUT_OFFSET, cfg_offset);
            apb_check(ADDR_DRIVE_LIMIT, cfg_limit);
            sender_idle_pct = int'(ph.sender_pct);
            recv_stall_pct  = int'(ph.recv_pct);
            hold_request    = int'(ph.hold);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph.pause_mid && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                if (run_left == 0) begin
                    run_kind = $urandom_range(9);
                    run_left = $urandom_range(12, 1);
                end
                run_left--;
                case (run_kind)
                    5, 6:    err = ssc_pkg::ERR_W'($urandom());
                    7:       err = 17'h0FFFF;
                    8:       err = 17'h10000;
                    9:       err = '0;
                    default: err = ssc_pkg::ERR_W'($urandom_range(600) - 300);
                endcase
                offer_sample(err, 1'b0, '0);
            end
            wait_drained();
        end

        if (expected_beats.size() != 0)
            flag_mismatch("result beats left over", 0, expected_beats.size());
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssc_pkg.sv
rtl/ssc_state_mem.sv
rtl/ssc_sequencer.sv
rtl/ssc_mac.sv
rtl/state_space_controller_4th_order.sv
dv/tb.sv
